FILE: rtl/letter_codeword_substitution_assert.svh
// Assertion macros shared by the checker of the codeword substitution block.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef LETTER_CODEWORD_SUBSTITUTION_ASSERT_SVH
`define LETTER_CODEWORD_SUBSTITUTION_ASSERT_SVH

// Next-cycle implication, ignored while reset is asserted.
`define LCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked during reset.
`define LCS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/lcs_pkg.sv
// Shared types, codes and helpers of the letter codeword substitution block.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package lcs_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ENCODE = 2'd1,
        CMD_DECODE = 2'd2,
        CMD_FLUSH  = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [3:0] entry_index;
        logic [3:0] char_pos;
        logic [7:0] entry_letter;
        logic [4:0] entry_length;
        logic [7:0] byte_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       last_of_run;
    } t_out_item;

    // One result handed from the sequencer to the output register.
    typedef struct packed {
        logic      load;
        t_out_item item;
    } t_out_load;

    // Window commands: append one byte at the tail, or drop one at the head.
    typedef struct packed {
        logic       append;
        logic       shift;
        logic [7:0] data;
    } t_win_ctrl;

    typedef struct packed {
        logic     we;
        t_in_item item;
    } t_tbl_wr;

    localparam logic [7:0] CH_UP_A = 8'h41;
    localparam logic [7:0] CH_UP_Z = 8'h5A;
    localparam logic [7:0] CH_LO_A = 8'h61;

    function automatic logic [7:0] fold_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_UP_A && c <= CH_UP_Z) begin
            r = c + (CH_LO_A - CH_UP_A);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/lcs_table.sv
// Codeword table: letters, lengths and the codeword byte memory.
// Depends on lcs_pkg; all reads are registered.
`timescale 1ns / 1ps
`default_nettype none

module lcs_table import lcs_pkg::*; #(
    parameter  int ENTRIES  = 16,
    parameter  int MAX_CODE = 16,
    localparam int KW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int PW = (MAX_CODE > 1) ? $clog2(MAX_CODE) : 1,
    localparam int LW = $clog2(MAX_CODE + 1)
) (
    input  wire logic          i_clk,
    input  wire t_tbl_wr       i_wr,
    input  wire logic [KW-1:0] i_rd_entry,
    output logic [7:0]         o_letter,
    output logic [LW-1:0]      o_length,
    input  wire logic [KW-1:0] i_mem_entry,
    input  wire logic [PW-1:0] i_mem_pos,
    output logic [7:0]         o_mem_q
);

    logic [7:0]    r_letter [ENTRIES];
    logic [LW-1:0] r_length [ENTRIES];
    logic [7:0]    r_code   [ENTRIES][MAX_CODE];
    logic [7:0]    r_letter_q;
    logic [LW-1:0] r_length_q;
    logic [7:0]    r_code_q;

    logic          idx_ok;
    logic          pos_ok;
    logic [31:0]   len_c;
    logic [KW-1:0] wr_entry;
    logic [PW-1:0] wr_pos;

    // A zero length is stored as one, an oversize length as the maximum.
    always_comb begin
        idx_ok   = 32'(i_wr.item.entry_index) < ENTRIES;
        pos_ok   = 32'(i_wr.item.char_pos) < MAX_CODE;
        len_c    = 32'(i_wr.item.entry_length);
        if (len_c == 32'd0) begin
            len_c = 32'd1;
        end
        if (len_c > MAX_CODE) begin
            len_c = MAX_CODE;
        end
        wr_entry = KW'(i_wr.item.entry_index);
        wr_pos   = PW'(i_wr.item.char_pos);
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we && idx_ok) begin
            r_letter[wr_entry] <= fold_lower(i_wr.item.entry_letter);
            r_length[wr_entry] <= LW'(len_c);
            if (pos_ok) begin
                r_code[wr_entry][wr_pos] <= i_wr.item.byte_in;
            end
        end
        r_letter_q <= r_letter[i_rd_entry];
        r_length_q <= r_length[i_rd_entry];
        r_code_q   <= r_code[i_mem_entry][i_mem_pos];
    end

    assign o_letter = r_letter_q;
    assign o_length = r_length_q;
    assign o_mem_q  = r_code_q;

endmodule

`default_nettype wire

FILE: rtl/lcs_window.sv
// Decode lookahead window: a shift line with a fill count.
// Depends on lcs_pkg for the window command type.
`timescale 1ns / 1ps
`default_nettype none

module lcs_window import lcs_pkg::*; #(
    parameter  int MAX_CODE = 16,
    localparam int PW = (MAX_CODE > 1) ? $clog2(MAX_CODE) : 1,
    localparam int LW = $clog2(MAX_CODE + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_win_ctrl     i_ctrl,
    input  wire logic [PW-1:0] i_rd_pos,
    output logic [7:0]         o_rd,
    output logic [7:0]         o_head,
    output logic [LW-1:0]      o_fill
);

    logic [7:0]    r_win [MAX_CODE];
    logic [LW-1:0] r_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            for (int i = 0; i < MAX_CODE; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_ctrl.append && (32'(r_fill) < MAX_CODE)) begin
            r_win[r_fill[PW-1:0]] <= i_ctrl.data;
            r_fill                <= r_fill + 1'b1;
        end else if (i_ctrl.shift && (r_fill != '0)) begin
            for (int i = 0; i < MAX_CODE - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[MAX_CODE-1] <= '0;
            r_fill            <= r_fill - 1'b1;
        end
    end

    assign o_rd   = r_win[i_rd_pos];
    assign o_head = r_win[0];
    assign o_fill = r_fill;

endmodule

`default_nettype wire

FILE: rtl/lcs_seq.sv
// Sequencer: steps the table and window through encode and decode matching.
// Depends on lcs_pkg; drives lcs_table and lcs_window from the top level.
`timescale 1ns / 1ps
`default_nettype none

module lcs_seq import lcs_pkg::*; #(
    parameter  int ENTRIES  = 16,
    parameter  int MAX_CODE = 16,
    localparam int KW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int KCW = $clog2(ENTRIES + 1),
    localparam int PW  = (MAX_CODE > 1) ? $clog2(MAX_CODE) : 1,
    localparam int LW  = $clog2(MAX_CODE + 1)
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire t_in_item       i_in,
    input  wire logic [KCW-1:0] i_act_entries,
    input  wire logic           i_out_free,
    output t_out_load           o_out_load,
    output t_tbl_wr             o_tbl_wr,
    output logic [KW-1:0]       o_tbl_entry,
    input  wire logic [7:0]     i_tbl_letter,
    input  wire logic [LW-1:0]  i_tbl_length,
    output logic [KW-1:0]       o_mem_entry,
    output logic [PW-1:0]       o_mem_pos,
    input  wire logic [7:0]     i_mem_q,
    output t_win_ctrl           o_win_ctrl,
    output logic [PW-1:0]       o_win_pos,
    input  wire logic [7:0]     i_win_rd,
    input  wire logic [7:0]     i_win_head,
    input  wire logic [LW-1:0]  i_win_fill
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_M_ADR,
        S_M_ENT,
        S_M_RD,
        S_M_CMP,
        S_M_OUT,
        S_M_SHIFT,
        S_E_ADR,
        S_E_ENT,
        S_E_PASS,
        S_E_RD,
        S_E_OUT
    } t_state;

    t_state         r_state;
    logic           r_flush;
    logic           r_found;
    logic [7:0]     r_byte;
    logic [KCW-1:0] r_k;
    logic [PW-1:0]  r_p;
    logic [KW-1:0]  r_best;
    logic [LW-1:0]  r_best_len;
    logic [7:0]     r_best_letter;
    logic [LW-1:0]  r_drop;

    logic           accept;
    logic           entry_end;
    logic           m_skip;
    logic           m_last_pos;
    logic           e_hit;
    logic           e_last;
    logic           full_after;
    logic [LW-1:0]  drop;

    always_comb begin
        accept     = i_in_valid && (r_state == S_IDLE);
        entry_end  = (r_k == i_act_entries);
        m_skip     = (i_tbl_length == '0) || (i_tbl_length > i_win_fill)
                     || (r_found && (i_tbl_length >= r_best_len));
        m_last_pos = (32'(r_p) + 32'd1) == 32'(i_tbl_length);
        e_hit      = (i_tbl_length != '0) && (i_tbl_letter == fold_lower(r_byte))
                     && (!r_found || (i_tbl_length < r_best_len));
        e_last     = (32'(r_p) + 32'd1) == 32'(r_best_len);
        full_after = (32'(i_win_fill) + 32'd1) >= MAX_CODE;
        drop       = r_found ? r_best_len : LW'(1);

        o_in_ready  = (r_state == S_IDLE);
        o_tbl_wr.we   = accept && (i_in.cmd == CMD_LOAD);
        o_tbl_wr.item = i_in;
        o_tbl_entry = r_k[KW-1:0];
        o_mem_entry = ((r_state == S_E_RD) || (r_state == S_E_OUT)) ? r_best : r_k[KW-1:0];
        o_mem_pos   = r_p;
        o_win_pos   = r_p;

        o_win_ctrl.append = accept && (i_in.cmd == CMD_DECODE);
        o_win_ctrl.shift  = (r_state == S_M_SHIFT);
        o_win_ctrl.data   = i_in.byte_in;

        o_out_load = '0;
        unique case (r_state)
            S_M_OUT: begin
                o_out_load.load                 = i_out_free;
                o_out_load.item.byte_out        = r_found ? r_best_letter : i_win_head;
                o_out_load.item.last_of_run     = !r_flush || (drop == i_win_fill);
            end
            S_E_PASS: begin
                o_out_load.load                 = i_out_free;
                o_out_load.item.byte_out        = r_byte;
                o_out_load.item.last_of_run     = 1'b1;
            end
            S_E_OUT: begin
                o_out_load.load                 = i_out_free;
                o_out_load.item.byte_out        = i_mem_q;
                o_out_load.item.last_of_run     = e_last;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_flush <= 1'b0;
            r_found <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        unique case (i_in.cmd)
                            CMD_LOAD: begin
                            end
                            CMD_ENCODE: begin
                                r_byte  <= i_in.byte_in;
                                r_k     <= '0;
                                r_found <= 1'b0;
                                r_state <= S_E_ADR;
                            end
                            CMD_DECODE: begin
                                if (full_after) begin
                                    r_k     <= '0;
                                    r_found <= 1'b0;
                                    r_flush <= 1'b0;
                                    r_state <= S_M_ADR;
                                end
                            end
                            CMD_FLUSH: begin
                                if (i_win_fill != '0) begin
                                    r_k     <= '0;
                                    r_found <= 1'b0;
                                    r_flush <= 1'b1;
                                    r_state <= S_M_ADR;
                                end
                            end
                        endcase
                    end
                end
                S_M_ADR: begin
                    r_state <= S_M_ENT;
                end
                S_M_ENT: begin
                    if (entry_end) begin
                        r_state <= S_M_OUT;
                    end else if (m_skip) begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_M_ADR;
                    end else begin
                        r_p     <= '0;
                        r_state <= S_M_RD;
                    end
                end
                S_M_RD: begin
                    r_state <= S_M_CMP;
                end
                S_M_CMP: begin
                    if (i_mem_q != i_win_rd) begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_M_ADR;
                    end else if (m_last_pos) begin
                        r_found       <= 1'b1;
                        r_best        <= r_k[KW-1:0];
                        r_best_len    <= i_tbl_length;
                        r_best_letter <= i_tbl_letter;
                        r_k           <= r_k + 1'b1;
                        r_state       <= S_M_ADR;
                    end else begin
                        r_p     <= r_p + 1'b1;
                        r_state <= S_M_RD;
                    end
                end
                S_M_OUT: begin
                    if (i_out_free) begin
                        r_drop  <= drop;
                        r_state <= S_M_SHIFT;
                    end
                end
                S_M_SHIFT: begin
                    r_drop <= r_drop - 1'b1;
                    if (r_drop == LW'(1)) begin
                        if (r_flush && (32'(i_win_fill) > 32'd1)) begin
                            r_k     <= '0;
                            r_found <= 1'b0;
                            r_state <= S_M_ADR;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_E_ADR: begin
                    r_state <= S_E_ENT;
                end
                S_E_ENT: begin
                    if (entry_end) begin
                        r_p     <= '0;
                        r_state <= r_found ? S_E_RD : S_E_PASS;
                    end else begin
                        if (e_hit) begin
                            r_found    <= 1'b1;
                            r_best     <= r_k[KW-1:0];
                            r_best_len <= i_tbl_length;
                        end
                        r_k     <= r_k + 1'b1;
                        r_state <= S_E_ADR;
                    end
                end
                S_E_PASS: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                S_E_RD: begin
                    r_state <= S_E_OUT;
                end
                S_E_OUT: begin
                    if (i_out_free) begin
                        if (e_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_p     <= r_p + 1'b1;
                            r_state <= S_E_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/letter_codeword_substitution.sv
// Top level of the letter codeword substitution block.
// Depends on lcs_pkg, lcs_table, lcs_window and lcs_seq.
//
//  Channel   Signals                            Moves
//  input     i_in_valid / o_in_ready / i_in     one t_in_item per accepted item
//  output    o_out_valid / i_out_ready / o_out  one t_out_item per result
//  config    i_cfg_we / i_cfg_data              entries_used, written at once
//
// Loads, decode items that leave the window short and empty flushes keep the sequencer idle.
// An encode scans the table one active entry at a time, then sends its byte or its codeword,
// one memory byte at a time. A decode match scans the same way and also compares codeword
// bytes one at a time through the single codeword read port, then gives one result and drops
// the window bytes one at a time. Reset is synchronous, no clearing pass. A result stalls the
// sequencer while the previous one waits.
`timescale 1ns / 1ps
`default_nettype none

module letter_codeword_substitution import lcs_pkg::*; #(
    parameter int ENTRIES  = 16,
    parameter int MAX_CODE = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in_item   i_in,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out_item       o_out,
    input  wire logic       i_cfg_we,
    input  wire logic [4:0] i_cfg_data
);

    localparam int KW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int KCW = $clog2(ENTRIES + 1);
    localparam int PW  = (MAX_CODE > 1) ? $clog2(MAX_CODE) : 1;
    localparam int LW  = $clog2(MAX_CODE + 1);

    // Configuration register: how many table entries take part in matching.
    logic [4:0]     r_entries_used;
    logic [KCW-1:0] act_entries;

    // Output register; it frees up in the same cycle its item is taken.
    logic           r_out_valid;
    t_out_item      r_out;
    logic           out_free;

    t_out_load      out_load;
    t_tbl_wr        tbl_wr;
    t_win_ctrl      win_ctrl;
    logic [KW-1:0]  tbl_entry;
    logic [7:0]     tbl_letter;
    logic [LW-1:0]  tbl_length;
    logic [KW-1:0]  mem_entry;
    logic [PW-1:0]  mem_pos;
    logic [7:0]     mem_q;
    logic [PW-1:0]  win_pos;
    logic [7:0]     win_rd;
    logic [7:0]     win_head;
    logic [LW-1:0]  win_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries_used <= '0;
        end else if (i_cfg_we) begin
            r_entries_used <= i_cfg_data;
        end
    end

    // Values above the table size count as the whole table.
    always_comb begin
        if (32'(r_entries_used) > ENTRIES) begin
            act_entries = KCW'(ENTRIES);
        end else begin
            act_entries = KCW'(r_entries_used);
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load.load) begin
            r_out <= out_load.item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    lcs_seq #(
        .ENTRIES  (ENTRIES),
        .MAX_CODE (MAX_CODE)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in          (i_in),
        .i_act_entries (act_entries),
        .i_out_free    (out_free),
        .o_out_load    (out_load),
        .o_tbl_wr      (tbl_wr),
        .o_tbl_entry   (tbl_entry),
        .i_tbl_letter  (tbl_letter),
        .i_tbl_length  (tbl_length),
        .o_mem_entry   (mem_entry),
        .o_mem_pos     (mem_pos),
        .i_mem_q       (mem_q),
        .o_win_ctrl    (win_ctrl),
        .o_win_pos     (win_pos),
        .i_win_rd      (win_rd),
        .i_win_head    (win_head),
        .i_win_fill    (win_fill)
    );

    lcs_table #(
        .ENTRIES  (ENTRIES),
        .MAX_CODE (MAX_CODE)
    ) u_table (
        .i_clk       (i_clk),
        .i_wr        (tbl_wr),
        .i_rd_entry  (tbl_entry),
        .o_letter    (tbl_letter),
        .o_length    (tbl_length),
        .i_mem_entry (mem_entry),
        .i_mem_pos   (mem_pos),
        .o_mem_q     (mem_q)
    );

    lcs_window #(
        .MAX_CODE (MAX_CODE)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (win_ctrl),
        .i_rd_pos (win_pos),
        .o_rd     (win_rd),
        .o_head   (win_head),
        .o_fill   (win_fill)
    );

endmodule

`default_nettype wire

FILE: rtl/lcs_checker.sv
// Port-level checker for the letter codeword substitution block, with its bind.
// Depends on lcs_pkg and letter_codeword_substitution_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "letter_codeword_substitution_assert.svh"

module lcs_checker import lcs_pkg::*; (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_ready,
    input wire t_in_item   i_in,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire t_out_item  o_out,
    input wire logic       i_cfg_we,
    input wire logic [4:0] i_cfg_data
);

    logic in_acc;
    logic cfg_seen;

    assign in_acc   = i_in_valid && o_in_ready;
    assign cfg_seen = i_cfg_we || (i_cfg_data != 5'd0);

    // A load item only writes the table, so the block is ready again at once.
    `LCS_ASSERT_NEXT(a_load_one_cycle, i_clk, i_rst_n,
        in_acc && (i_in.cmd == CMD_LOAD), o_in_ready, "load item did not finish in one cycle")

    // An encode item always scans the table, so the block is busy after it.
    `LCS_ASSERT_NEXT(a_encode_busy, i_clk, i_rst_n,
        in_acc && (i_in.cmd == CMD_ENCODE), !o_in_ready, "ready right after an encode item")

    // A result that is not taken stays, unchanged.
    `LCS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready, o_out_valid && $stable(o_out), "stalled result changed")

    // Reset leaves no result pending and the block ready for an item.
    `LCS_ASSERT_NEXT_ALWAYS(a_reset_clean, i_clk,
        !i_rst_n && !cfg_seen, !o_out_valid && o_in_ready, "result or busy state after reset")

endmodule

bind letter_codeword_substitution lcs_checker u_lcs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_data  (i_cfg_data)
);

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for the letter codeword substitution block.
// Depends on lcs_pkg and the letter_codeword_substitution top level.
// Predicts every output byte from its own model of the table and the decode window.
`timescale 1ns / 1ps

module testbench;
    import lcs_pkg::*;

    localparam int NUM_ENTRIES    = 16;
    localparam int CODE_MAX       = 16;
    // Settling time after the last result: enough for the worst decode match, a full
    // table of sixteen-byte codewords compared byte by byte, then the drop.
    localparam int SETTLE_CYCLES  = 700;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;

    localparam logic [7:0] UPPER_A = 8'h41;
    localparam logic [7:0] UPPER_Z = 8'h5A;
    localparam logic [7:0] LOWER_A = 8'h61;
    localparam logic [7:0] LOWER_Z = 8'h7A;
    localparam logic [7:0] DIGIT_0 = 8'h30;

    // Block ports. Every input starts at a known value.
    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in        = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out;
    logic      i_cfg_we    = 1'b0;
    logic [4:0] i_cfg_data = '0;

    letter_codeword_substitution #(
        .ENTRIES  (NUM_ENTRIES),
        .MAX_CODE (CODE_MAX)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: the codeword table, the lookahead window and the
    // entry count, updated as each item is accepted by the block.
    // ------------------------------------------------------------------
    logic [7:0] sub_letter [NUM_ENTRIES];
    logic [4:0] sub_len    [NUM_ENTRIES];
    logic [7:0] sub_code   [NUM_ENTRIES][CODE_MAX];
    logic [7:0] win_bytes  [CODE_MAX];
    int         win_fill;
    logic [4:0] used_cfg;

    t_in_item  pending_items[$];
    t_out_item expected_bytes[$];

    // Stimulus-side view of the table. It tracks which codeword bytes have
    // been written so that no encode or decode ever reaches an unwritten entry.
    logic [7:0]  plan_letter [NUM_ENTRIES];
    int          plan_len    [NUM_ENTRIES];
    logic [7:0]  plan_code   [NUM_ENTRIES][CODE_MAX];
    logic [15:0] plan_mask   [NUM_ENTRIES];
    bit          plan_has    [NUM_ENTRIES];
    int          plan_active;

    // Bench controls and counters.
    logic calm_mode        = 1'b0;
    logic backpressure_req = 1'b0;
    int   fail_count       = 0;
    int   items_taken      = 0;
    int   loads_taken      = 0;
    int   results_seen     = 0;
    int   cfg_writes       = 0;
    int   text_items       = 0;

    function automatic logic [7:0] lower_case(input logic [7:0] c);
        if (c >= UPPER_A && c <= UPPER_Z) begin
            return c + (LOWER_A - UPPER_A);
        end
        return c;
    endfunction

    // A length of zero is kept as one, anything past the codeword limit as the limit.
    function automatic int clamp_length(input logic [4:0] raw);
        if (raw == 0) begin
            return 1;
        end
        if (int'(raw) > CODE_MAX) begin
            return CODE_MAX;
        end
        return int'(raw);
    endfunction

    // Entry counts above the table size behave as the full table.
    function automatic int active_limit(input logic [4:0] v);
        return (int'(v) > NUM_ENTRIES) ? NUM_ENTRIES : int'(v);
    endfunction

    function automatic void push_result(input logic [7:0] b, input logic last);
        t_out_item r;
        r.byte_out    = b;
        r.last_of_run = last;
        expected_bytes.push_back(r);
    endfunction

    // Matches the window head against the active codewords. The shortest
    // codeword that prefixes the window wins, ties go to the lower index.
    // A match yields the letter and drops the codeword; otherwise the head
    // byte passes through alone.
    function automatic logic [7:0] decode_head();
        int n;
        int best;
        int best_len;
        int len;
        int drop;
        bit same;
        logic [7:0] outb;
        n        = active_limit(used_cfg);
        best     = -1;
        best_len = 0;
        for (int k = 0; k < n; k++) begin
            len = int'(sub_len[k]);
            if (len == 0 || len > win_fill) begin
                continue;
            end
            same = 1'b1;
            for (int p = 0; p < len; p++) begin
                if (sub_code[k][p] != win_bytes[p]) begin
                    same = 1'b0;
                end
            end
            if (same && (best < 0 || len < best_len)) begin
                best     = k;
                best_len = len;
            end
        end
        outb = win_bytes[0];
        drop = 1;
        if (best >= 0) begin
            outb = sub_letter[best];
            drop = best_len;
        end
        for (int i = 0; i < CODE_MAX; i++) begin
            win_bytes[i] = (i + drop < CODE_MAX) ? win_bytes[i + drop] : 8'h00;
        end
        win_fill -= drop;
        return outb;
    endfunction

    // Works out the bytes that one accepted item must produce.
    function automatic void predict_item(input t_in_item it);
        int len;
        int n;
        int best;
        int best_len;
        logic [7:0] f;
        logic [7:0] outb;
        case (it.cmd)
            CMD_LOAD: begin
                len = clamp_length(it.entry_length);
                sub_letter[it.entry_index]              = lower_case(it.entry_letter);
                sub_len[it.entry_index]                 = 5'(len);
                sub_code[it.entry_index][it.char_pos]   = it.byte_in;
            end
            CMD_ENCODE: begin
                f        = lower_case(it.byte_in);
                n        = active_limit(used_cfg);
                best     = -1;
                best_len = 0;
                for (int k = 0; k < n; k++) begin
                    if (sub_len[k] == 0 || sub_letter[k] != f) begin
                        continue;
                    end
                    if (best < 0 || int'(sub_len[k]) < best_len) begin
                        best     = k;
                        best_len = int'(sub_len[k]);
                    end
                end
                if (best < 0) begin
                    push_result(it.byte_in, 1'b1);
                end else begin
                    for (int k = 0; k < best_len; k++) begin
                        push_result(sub_code[best][k], k == best_len - 1);
                    end
                end
            end
            CMD_DECODE: begin
                if (win_fill < CODE_MAX) begin
                    win_bytes[win_fill] = it.byte_in;
                    win_fill++;
                end
                if (win_fill == CODE_MAX) begin
                    push_result(decode_head(), 1'b1);
                end
            end
            default: begin
                // Flush drains the window; an empty window gives nothing.
                while (win_fill > 0) begin
                    outb = decode_head();
                    push_result(outb, win_fill == 0);
                end
            end
        endcase
    endfunction

    // Mostly zero, often a few cycles, now and then a long stretch.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers pending items, holds each one until it is taken, and
    // predicts the results of every item at the edge that accepts it.
    // ------------------------------------------------------------------
    int in_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap     <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_item(i_in);
                items_taken++;
                if (i_in.cmd == CMD_LOAD) begin
                    loads_taken++;
                end
            end
            if (i_in_valid && !o_in_ready) begin
                // The offered item stays put until the block takes it.
            end else if (in_gap > 0) begin
                in_gap     <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                i_in       <= pending_items.pop_front();
                i_in_valid <= 1'b1;
                in_gap     <= calm_mode ? 0 : gap_len();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: takes results with random stalls, plus one long hold-off
    // on request so that the block backs up and stops taking items, and
    // checks every result against the oldest expected byte.
    // ------------------------------------------------------------------
    int   stall_left = 0;
    int   hold_left  = 0;
    logic hold_done  = 1'b0;
    t_out_item want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left  <= 0;
            hold_left   <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_bytes.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("unexpected result: byte %h last %b",
                                 o_out.byte_out, o_out.last_of_run);
                    end
                end else begin
                    want = expected_bytes.pop_front();
                    if (o_out.byte_out !== want.byte_out ||
                        o_out.last_of_run !== want.last_of_run) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display("result %0d: expected byte %h last %b, got byte %h last %b",
                                     results_seen, want.byte_out, want.last_of_run,
                                     o_out.byte_out, o_out.last_of_run);
                        end
                    end
                end
                results_seen++;
            end
            if (backpressure_req && !hold_done) begin
                hold_done   <= 1'b1;
                hold_left   <= HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left   <= hold_left - 1;
                i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left  <= stall_left - 1;
                i_out_ready <= 1'b0;
            end else if (!calm_mode && $urandom_range(0, 99) < 25) begin
                stall_left  <= gap_len();
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: a long run of cycles with no handshake on either side means
    // the block has hung or dropped results.
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("no handshake for %0d cycles, %0d results still outstanding",
                     quiet_cycles, expected_bytes.size());
            $display("testbench failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // Fields an item does not use carry random bits.
    function automatic t_in_item rand_item(input t_cmd c);
        logic [$bits(t_in_item)-1:0] r;
        t_in_item it;
        r       = $bits(t_in_item)'($urandom);
        it      = t_in_item'(r);
        it.cmd  = c;
        return it;
    endfunction

    // Codeword bytes come mostly from a four-symbol alphabet so that
    // codewords often prefix each other and decode matches are frequent.
    function automatic logic [7:0] code_byte();
        if ($urandom_range(0, 99) < 85) begin
            return DIGIT_0 + 8'($urandom_range(0, 3));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic bit entry_ready(input int e);
        logic [15:0] need;
        need = 16'((32'd1 << plan_len[e]) - 1);
        return plan_has[e] && ((plan_mask[e] & need) == need);
    endfunction

    task automatic load_byte(input int e, input logic [7:0] letter, input logic [4:0] raw,
                             input int pos, input logic [7:0] b);
        t_in_item it;
        it              = rand_item(CMD_LOAD);
        it.entry_index  = 4'(e);
        it.char_pos     = 4'(pos);
        it.entry_letter = letter;
        it.entry_length = raw;
        it.byte_in      = b;
        pending_items.push_back(it);
        plan_has[e]       = 1'b1;
        plan_letter[e]    = letter;
        plan_len[e]       = clamp_length(raw);
        plan_code[e][pos] = b;
        plan_mask[e][pos] = 1'b1;
    endtask

    // Writes a whole entry as one unbroken run of loads, so no decode or
    // encode can see it half written.
    task automatic load_entry(input int e);
        logic [7:0] letter;
        logic [4:0] raw;
        int len;
        int start;
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            letter = ($urandom_range(0, 1) ? UPPER_A : LOWER_A) + 8'($urandom_range(0, 4));
        end else if (r < 80) begin
            letter = $urandom_range(0, 1) ? UPPER_Z : LOWER_Z;
        end else begin
            letter = 8'($urandom_range(0, 255));
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            raw = 5'($urandom_range(1, 3));
        end else if (r < 75) begin
            raw = 5'($urandom_range(4, 6));
        end else if (r < 82) begin
            raw = 5'd0;
        end else if (r < 90) begin
            raw = 5'($urandom_range(17, 31));
        end else begin
            raw = 5'($urandom_range(7, 16));
        end
        len   = clamp_length(raw);
        start = $urandom_range(0, len - 1);
        for (int i = 0; i < len; i++) begin
            load_byte(e, letter, raw, (start + i) % len, code_byte());
        end
        // Now and then a spare byte past the end of the codeword.
        if ($urandom_range(0, 9) == 0 && len < CODE_MAX) begin
            load_byte(e, letter, raw, $urandom_range(len, CODE_MAX - 1), code_byte());
        end
    endtask

    task automatic send_text(input t_cmd c, input logic [7:0] b);
        t_in_item it;
        it         = rand_item(c);
        it.byte_in = b;
        pending_items.push_back(it);
        text_items++;
    endtask

    task automatic send_encode();
        logic [7:0] b;
        int e;
        if (plan_active > 0 && $urandom_range(0, 99) < 80) begin
            e = $urandom_range(0, plan_active - 1);
            b = plan_letter[e];
            // Flip the case at random; encode must fold it either way.
            if ($urandom_range(0, 1)) begin
                if (b >= LOWER_A && b <= LOWER_Z) begin
                    b = b - (LOWER_A - UPPER_A);
                end else if (b >= UPPER_A && b <= UPPER_Z) begin
                    b = b + (LOWER_A - UPPER_A);
                end
            end
        end else begin
            b = 8'($urandom_range(0, 255));
        end
        send_text(CMD_ENCODE, b);
    endtask

    // Mostly a whole codeword of an active entry, otherwise one stray byte.
    task automatic send_decode_word();
        int e;
        if (plan_active > 0 && $urandom_range(0, 99) < 85) begin
            e = $urandom_range(0, plan_active - 1);
            for (int p = 0; p < plan_len[e]; p++) begin
                send_text(CMD_DECODE, plan_code[e][p]);
            end
        end else begin
            send_text(CMD_DECODE, $urandom_range(0, 1) ? code_byte() : 8'($urandom_range(0, 255)));
        end
    endtask

    // Waits until every item is taken and every result has come, then lets
    // the block finish any work that produces no result.
    task automatic wait_idle();
        while (pending_items.size() != 0 || i_in_valid || expected_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Completes every entry that the new count brings in, then writes the
    // register while the block is idle.
    task automatic set_active(input logic [4:0] v);
        for (int e = 0; e < active_limit(v); e++) begin
            if (!entry_ready(e)) begin
                load_entry(e);
            end
        end
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        used_cfg    = v;
        plan_active = active_limit(v);
        cfg_writes++;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic run_phase(input logic [4:0] v, input int quota, input logic calm,
                             input logic squeeze);
        int target;
        int r;
        set_active(v);
        calm_mode        <= calm;
        backpressure_req <= squeeze;
        target = text_items + quota;
        while (text_items < target) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                send_encode();
            end else if (r < 75) begin
                send_decode_word();
            end else if (r < 83) begin
                send_text(CMD_FLUSH, 8'($urandom_range(0, 255)));
            end else if (r < 93 && plan_active > 0) begin
                load_entry($urandom_range(0, plan_active - 1));
            end else if (plan_active < NUM_ENTRIES) begin
                // A stray load on an entry outside the active range.
                load_byte($urandom_range(plan_active, NUM_ENTRIES - 1),
                          8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                          $urandom_range(0, CODE_MAX - 1), 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial begin
        for (int e = 0; e < NUM_ENTRIES; e++) begin
            sub_letter[e] = '0;
            sub_len[e]    = '0;
            plan_letter[e] = '0;
            plan_len[e]    = 0;
            plan_mask[e]   = '0;
            plan_has[e]    = 1'b0;
            for (int p = 0; p < CODE_MAX; p++) begin
                sub_code[e][p]  = '0;
                plan_code[e][p] = '0;
            end
        end
        for (int p = 0; p < CODE_MAX; p++) begin
            win_bytes[p] = '0;
        end
        win_fill    = 0;
        used_cfg    = '0;
        plan_active = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. With no active entries every encoded byte passes
        // through, and a flush of an empty window yields nothing.
        send_text(CMD_ENCODE, "A");
        send_text(CMD_ENCODE, 8'hFF);
        send_text(CMD_ENCODE, 8'h00);
        send_text(CMD_FLUSH, 8'h00);
        // A short window drained by flush passes its bytes straight out.
        send_text(CMD_DECODE, "q");
        send_text(CMD_DECODE, "r");
        send_text(CMD_DECODE, 8'h80);
        send_text(CMD_FLUSH, 8'hFF);

        // Table: an upper-case letter with a zero length, a longer codeword
        // for the same letter, the last upper-case letter, and a second
        // one-byte entry with the same codeword as entry 0.
        load_byte(0, "A", 5'd0, 0, "x");
        load_byte(1, "a", 5'd2, 1, "y");
        load_byte(1, "a", 5'd2, 0, "x");
        load_byte(2, "Z", 5'd1, 0, "w");
        load_byte(3, "b", 5'd1, 0, "x");
        set_active(5'd4);

        // The shorter of two codewords for one letter wins; fold edges.
        send_text(CMD_ENCODE, "A");
        send_text(CMD_ENCODE, "z");
        send_text(CMD_ENCODE, "Z");
        send_text(CMD_ENCODE, "[");
        send_text(CMD_ENCODE, "@");
        send_text(CMD_ENCODE, "b");
        // Entries 0 and 3 tie on "x"; the lower index takes it.
        send_text(CMD_DECODE, "x");
        send_text(CMD_DECODE, "y");
        send_text(CMD_DECODE, "q");
        send_text(CMD_FLUSH, 8'h00);

        // Random phases over several entry counts, the extremes among them.
        // The first runs without idling and with one long output hold-off.
        run_phase(5'd16, 28, 1'b1, 1'b1);
        run_phase(5'd3,  28, 1'b0, 1'b0);
        run_phase(5'd31, 28, 1'b0, 1'b0);
        run_phase(5'd1,  24, 1'b0, 1'b0);
        run_phase(5'd8,  28, 1'b0, 1'b0);
        run_phase(5'd0,  20, 1'b0, 1'b0);
        run_phase(5'd17, 28, 1'b0, 1'b0);
        run_phase(5'd12, 24, 1'b0, 1'b0);
        send_text(CMD_FLUSH, 8'h00);

        wait_idle();
        $display("covered %0d items (%0d table loads) over %0d entry-count settings,",
                 items_taken, loads_taken, cfg_writes);
        $display("%0d result bytes checked, %0d failures", results_seen, fail_count);
        if (fail_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/lcs_pkg.sv
rtl/lcs_table.sv
rtl/lcs_window.sv
rtl/lcs_seq.sv
rtl/letter_codeword_substitution.sv
rtl/lcs_checker.sv
bench/testbench.sv
